/* src/swirl_warp_coordinate_map_top_assert.svh */
// ---------------------------------------------------------------------------
// Swirl warp assertion macros
// Implication checks on the block clock, masked during reset.
// ---------------------------------------------------------------------------
`ifndef SWIRL_WARP_COORDINATE_MAP_TOP_ASSERT_SVH
`define SWIRL_WARP_COORDINATE_MAP_TOP_ASSERT_SVH
// same-cycle implication
`define SWM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SWM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* src/swm_pkg.sv */
// ---------------------------------------------------------------------------
// Swirl warp package
// Fixed widths, register indexes and series divisors.
// ---------------------------------------------------------------------------
`default_nettype none
package swm_pkg;
  localparam int SIZE_W = 13;
  localparam int N_HORNER = 5;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd480;

  localparam int COS_DIV [N_HORNER] = '{90, 56, 30, 12, 2};
  localparam int SIN_DIV [N_HORNER] = '{72, 42, 20, 6, 1};
  localparam int SIN_USE [N_HORNER] = '{1, 1, 1, 1, 0};
endpackage
`default_nettype wire

/* src/swm_if.sv */
// ---------------------------------------------------------------------------
// Swirl warp channels
// Valid/ready channels for coordinate beats and source index beats.
// ---------------------------------------------------------------------------
`default_nettype none
interface swm_in_if #(parameter int COORD_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;
  modport source (output valid, output out_x, output out_y, input ready);
  modport sink   (input valid, input out_x, input out_y, output ready);
endinterface

interface swm_out_if #(parameter int COORD_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] src_x;
  logic [COORD_BITS-1:0] src_y;
  logic                  inside_disc;
  modport source (output valid, output src_x, output src_y, output inside_disc,
                  input ready);
  modport sink   (input valid, input src_x, input src_y, input inside_disc,
                  output ready);
endinterface
`default_nettype wire

/* src/swm_div_cell.sv */
// ---------------------------------------------------------------------------
// Swirl warp divider cell
// One restoring quotient bit per cell for the x and y lanes.
// ---------------------------------------------------------------------------
`default_nettype none
module swm_div_cell #(
  parameter int DW = 29,
  parameter int TW = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                vi,
  input  logic [1:0][swm_pkg::SIZE_W-1:0]     d,
  input  logic [1:0][swm_pkg::SIZE_W-1:0]     rem_i,
  input  logic [1:0][DW-1:0]                  nq_i,
  input  logic [TW-1:0]                       tag_i,
  output logic                                vo,
  output logic [1:0][swm_pkg::SIZE_W-1:0]     rem_o,
  output logic [1:0][DW-1:0]                  nq_o,
  output logic [TW-1:0]                       tag_o
);
  import swm_pkg::*;

  logic [1:0][SIZE_W-1:0] rem_nxt;
  logic [1:0][DW-1:0]     nq_nxt;
  logic [1:0][SIZE_W:0]   t;
  logic [1:0][SIZE_W:0]   diff;
  logic [1:0]             ge;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      t[l]       = {rem_i[l], nq_i[l][DW-1]};
      diff[l]    = t[l] - {1'b0, d[l]};
      ge[l]      = t[l] >= {1'b0, d[l]};
      rem_nxt[l] = ge[l] ? diff[l][SIZE_W-1:0] : t[l][SIZE_W-1:0];
      nq_nxt[l]  = {nq_i[l][DW-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo <= 1'b0;
    end else if (en) begin
      vo <= vi;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= rem_nxt;
      nq_o  <= nq_nxt;
      tag_o <= tag_i;
    end
  end
endmodule
`default_nettype wire

/* src/swm_sqrt_cell.sv */
// ---------------------------------------------------------------------------
// Swirl warp square root cell
// One root bit per cell, two radicand bits consumed per cell.
// ---------------------------------------------------------------------------
`default_nettype none
module swm_sqrt_cell #(
  parameter int RW = 34,
  parameter int QW = 17,
  parameter int TW = 60
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vi,
  input  logic [QW:0]   rem_i,
  input  logic [QW-1:0] root_i,
  input  logic [RW-1:0] rad_i,
  input  logic [TW-1:0] tag_i,
  output logic          vo,
  output logic [QW:0]   rem_o,
  output logic [QW-1:0] root_o,
  output logic [RW-1:0] rad_o,
  output logic [TW-1:0] tag_o
);
  logic [QW+2:0] t;
  logic [QW+2:0] trial;
  logic [QW+2:0] diff;
  logic          ge;
  logic [QW:0]   rem_nxt;
  logic [QW-1:0] root_nxt;
  logic [RW-1:0] rad_nxt;

  always_comb begin
    t        = {rem_i, rad_i[RW-1:RW-2]};
    trial    = {1'b0, root_i, 2'b01};
    diff     = t - trial;
    ge       = t >= trial;
    rem_nxt  = ge ? diff[QW:0] : t[QW:0];
    root_nxt = {root_i[QW-2:0], ge};
    rad_nxt  = {rad_i[RW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo <= 1'b0;
    end else if (en) begin
      vo <= vi;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= rem_nxt;
      root_o <= root_nxt;
      rad_o  <= rad_nxt;
      tag_o  <= tag_i;
    end
  end
endmodule
`default_nettype wire

/* src/swm_horner_cell.sv */
// ---------------------------------------------------------------------------
// Swirl warp series cell
// One Horner step of the cosine and sine series in three stages:
// product, reciprocal multiply, quotient correction.
// ---------------------------------------------------------------------------
`default_nettype none
module swm_horner_cell #(
  parameter int F      = 16,
  parameter int DC     = 2,
  parameter int DS     = 1,
  parameter int SIN_EN = 1,
  parameter int TW     = 77
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vi,
  input  logic [F:0]    t2_i,
  input  logic [F:0]    sc_i,
  input  logic [F:0]    ss_i,
  input  logic [TW-1:0] tag_i,
  output logic          vo,
  output logic [F:0]    t2_o,
  output logic [F:0]    sc_o,
  output logic [F:0]    ss_o,
  output logic [TW-1:0] tag_o
);
  localparam int K = F + 2;
  localparam longint unsigned MCL = (64'd1 << K) / DC;
  localparam longint unsigned MSL = (64'd1 << K) / DS;
  localparam logic [K:0]   MC  = (K+1)'(MCL);
  localparam logic [K:0]   MS  = (K+1)'(MSL);
  localparam logic [F+8:0] DCV = (F+9)'(DC);
  localparam logic [F+8:0] DSV = (F+9)'(DS);
  localparam logic [F:0]   ONE = {1'b1, {F{1'b0}}};

  logic [2*F+1:0] pc_full, ps_full;
  logic [2*F+3:0] mc_full, ms_full;
  logic [F+8:0]   rc, rs;
  logic [F:0]     qc, qs;
  logic [F:0]     sc_nxt, ss_nxt;

  logic          va_r, vb_r;
  logic [F:0]    t2a_r, pca_r, psa_r, ssa_r;
  logic [TW-1:0] taga_r;
  logic [F:0]    t2b_r, pcb_r, psb_r, qcb_r, qsb_r, ssb_r;
  logic [TW-1:0] tagb_r;

  always_comb begin
    pc_full = t2_i * sc_i;
    ps_full = t2_i * ss_i;
    mc_full = pca_r * MC;
    ms_full = psa_r * MS;
    rc      = (F+9)'(pcb_r) - (F+9)'(qcb_r) * DCV;
    rs      = (F+9)'(psb_r) - (F+9)'(qsb_r) * DSV;
    qc      = (rc >= DCV) ? qcb_r + 1'b1 : qcb_r;
    qs      = (rs >= DSV) ? qsb_r + 1'b1 : qsb_r;
    sc_nxt  = ONE - qc;
    ss_nxt  = (SIN_EN != 0) ? ONE - qs : ssb_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vo   <= 1'b0;
    end else if (en) begin
      va_r <= vi;
      vb_r <= va_r;
      vo   <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t2a_r  <= t2_i;
      pca_r  <= pc_full[2*F:F];
      psa_r  <= ps_full[2*F:F];
      ssa_r  <= ss_i;
      taga_r <= tag_i;
      t2b_r  <= t2a_r;
      pcb_r  <= pca_r;
      psb_r  <= psa_r;
      qcb_r  <= mc_full[K+F:K];
      qsb_r  <= ms_full[K+F:K];
      ssb_r  <= ssa_r;
      tagb_r <= taga_r;
      t2_o   <= t2b_r;
      sc_o   <= sc_nxt;
      ss_o   <= ss_nxt;
      tag_o  <= tagb_r;
    end
  end
endmodule
`default_nettype wire

/* src/swirl_warp_coordinate_map_top.sv */
// ---------------------------------------------------------------------------
// Swirl warp coordinate map
// Maps an output pixel coordinate to the source coordinate of a swirl warp.
// ---------------------------------------------------------------------------
// One coordinate beat is accepted every clock while the output buffer has room;
// in_bus.ready drops while the skid entry is full. Each one gives one source
// index beat. The pipeline is a row of single-step cells: COORD_BITS+FRAC_BITS+1
// divider cells for the normalization, FRAC_BITS+1 square root cells and five
// three-stage series cells, plus the multiply stages between them. A two-beat
// output buffer lets the block keep taking beats while one result waits. Width
// and height are written over the APB port at 0x0 and 0x4; the user must write
// them only while no beat is in flight, which the block itself does not enforce.
`default_nettype none
module swirl_warp_coordinate_map_top #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  swm_in_if.sink      in_bus,
  swm_out_if.source   out_bus,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import swm_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int DW  = C + F + 1;
  localparam int RW  = 2 * F + 2;
  localparam int QW  = F + 1;
  localparam int LB  = (C > SIZE_W) ? C : SIZE_W;
  localparam int TW1 = 2 * C;
  localparam int TW2 = 1 + 2 * (F + 2) + 2 * C;
  localparam int TW3 = (F + 1) + TW2;
  localparam logic [F:0]    ONE  = {1'b1, {F{1'b0}}};
  localparam logic [DW-1:0] QLIM = {{(C-1){1'b0}}, 1'b1, {(F+1){1'b0}}};
  localparam logic [RW-1:0] R2LIM = {2'b01, {(2*F){1'b0}}};
  localparam logic [LB-1:0] CMAX = {{(LB-C){1'b0}}, {C{1'b1}}};

  // configuration
  logic [SIZE_W-1:0] width_r, height_r;
  logic [SIZE_W-1:0] wsize, hsize;
  logic [LB-1:0]     limx, limy, wm1, hm1;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_WIDTH:  width_r  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT: height_r <= pwdata[SIZE_W-1:0];
        default:    width_r  <= width_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WIDTH:  prdata = {{(32-SIZE_W){1'b0}}, width_r};
      REG_HEIGHT: prdata = {{(32-SIZE_W){1'b0}}, height_r};
      default:    prdata = '0;
    endcase
  end

  assign wsize = (width_r == '0) ? SIZE_W'(1) : width_r;
  assign hsize = (height_r == '0) ? SIZE_W'(1) : height_r;
  assign wm1   = LB'(wsize - 1'b1);
  assign hm1   = LB'(hsize - 1'b1);
  assign limx  = (wm1 > CMAX) ? CMAX : wm1;
  assign limy  = (hm1 > CMAX) ? CMAX : hm1;

  function automatic logic [C-1:0] clamp_idx(logic signed [17:0] v, logic [LB-1:0] lim);
    logic signed [17:0] ls;
    ls = $signed({{(18-LB){1'b0}}, lim});
    if (v < 0) begin
      clamp_idx = '0;
    end else if (v > ls) begin
      clamp_idx = lim[C-1:0];
    end else begin
      clamp_idx = v[C-1:0];
    end
  endfunction

  // flow control
  logic en;
  logic out_valid_r, skid_valid_r;
  logic push, pop;

  assign en           = !skid_valid_r;
  assign in_bus.ready = en;

  // divider chain
  logic [1:0][SIZE_W-1:0] drem [DW+1];
  logic [1:0][DW-1:0]     dnq  [DW+1];
  logic [TW1-1:0]         dtag [DW+1];
  logic                   dv   [DW+1];
  logic [1:0][SIZE_W-1:0] dsz;

  assign dsz     = {hsize, wsize};
  assign dv[0]   = in_bus.valid;
  assign drem[0] = '0;
  assign dnq[0]  = {{in_bus.out_y, {(F+1){1'b0}}}, {in_bus.out_x, {(F+1){1'b0}}}};
  assign dtag[0] = {in_bus.out_x, in_bus.out_y};

  for (genvar i = 0; i < DW; i++) begin : g_div
    swm_div_cell #(.DW(DW), .TW(TW1)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .vi(dv[i]), .d(dsz),
      .rem_i(drem[i]), .nq_i(dnq[i]), .tag_i(dtag[i]),
      .vo(dv[i+1]), .rem_o(drem[i+1]), .nq_o(dnq[i+1]), .tag_o(dtag[i+1])
    );
  end

  // center, square
  logic [DW-1:0]        qx, qy;
  logic signed [F+2:0]  xct, yct;
  logic signed [F+1:0]  xcc, ycc;
  logic signed [2*F+3:0] sqxc, sqyc;
  logic                 v1_r, inr1_r;
  logic signed [F+1:0]  xc1_r, yc1_r;
  logic [2*F:0]         sqx1_r, sqy1_r;
  logic [TW1-1:0]       tag1_r;

  always_comb begin
    qx   = dnq[DW][0];
    qy   = dnq[DW][1];
    xct  = $signed({1'b0, qx[F+1:0]}) - $signed({2'b00, ONE});
    yct  = $signed({1'b0, qy[F+1:0]}) - $signed({2'b00, ONE});
    xcc  = xct[F+1:0];
    ycc  = yct[F+1:0];
    sqxc = xcc * xcc;
    sqyc = ycc * ycc;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inr1_r <= (qx <= QLIM) && (qy <= QLIM);
      xc1_r  <= xcc;
      yc1_r  <= ycc;
      sqx1_r <= sqxc[2*F:0];
      sqy1_r <= sqyc[2*F:0];
      tag1_r <= dtag[DW];
    end
  end

  // radius squared, disc test
  logic [RW-1:0]  r2;
  logic           in2;
  logic           v2_r;
  logic [RW-1:0]  rad2_r;
  logic [TW2-1:0] tag2_r;

  assign r2  = {1'b0, sqx1_r} + {1'b0, sqy1_r};
  assign in2 = inr1_r && (r2 <= R2LIM);

  always_ff @(posedge clk) begin
    if (en) begin
      rad2_r <= in2 ? r2 : '0;
      tag2_r <= {in2, xc1_r, yc1_r, tag1_r};
    end
  end

  // square root chain
  logic [QW:0]    srem  [QW+1];
  logic [QW-1:0]  sroot [QW+1];
  logic [RW-1:0]  srad  [QW+1];
  logic [TW2-1:0] stag  [QW+1];
  logic           sv    [QW+1];

  assign sv[0]    = v2_r;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign srad[0]  = rad2_r;
  assign stag[0]  = tag2_r;

  for (genvar i = 0; i < QW; i++) begin : g_sqrt
    swm_sqrt_cell #(.RW(RW), .QW(QW), .TW(TW2)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .vi(sv[i]),
      .rem_i(srem[i]), .root_i(sroot[i]), .rad_i(srad[i]), .tag_i(stag[i]),
      .vo(sv[i+1]), .rem_o(srem[i+1]), .root_o(sroot[i+1]), .rad_o(srad[i+1]),
      .tag_o(stag[i+1])
    );
  end

  // angle and its square
  logic [F:0]       tt;
  logic [2*F+1:0]   thf, t2f;
  logic             v3_r, v4_r;
  logic [F:0]       th3_r, th4_r, t24_r;
  logic [TW2-1:0]   tag3_r, tag4_r;

  assign tt  = ONE - sroot[QW];
  assign thf = tt * tt;
  assign t2f = th3_r * th3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      th3_r  <= thf[2*F:F];
      tag3_r <= stag[QW];
      th4_r  <= th3_r;
      t24_r  <= t2f[2*F:F];
      tag4_r <= tag3_r;
    end
  end

  // series chain
  logic [F:0]     ht2 [N_HORNER+1];
  logic [F:0]     hsc [N_HORNER+1];
  logic [F:0]     hss [N_HORNER+1];
  logic [TW3-1:0] htag [N_HORNER+1];
  logic           hv  [N_HORNER+1];

  assign hv[0]   = v4_r;
  assign ht2[0]  = t24_r;
  assign hsc[0]  = ONE;
  assign hss[0]  = ONE;
  assign htag[0] = {th4_r, tag4_r};

  for (genvar k = 0; k < N_HORNER; k++) begin : g_series
    swm_horner_cell #(
      .F(F), .DC(COS_DIV[k]), .DS(SIN_DIV[k]), .SIN_EN(SIN_USE[k]), .TW(TW3)
    ) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .vi(hv[k]),
      .t2_i(ht2[k]), .sc_i(hsc[k]), .ss_i(hss[k]), .tag_i(htag[k]),
      .vo(hv[k+1]), .t2_o(ht2[k+1]), .sc_o(hsc[k+1]), .ss_o(hss[k+1]),
      .tag_o(htag[k+1])
    );
  end

  // sine, rotate, denormalize
  logic [F:0]           th5c;
  logic [2*F+1:0]       snf;
  logic                 in5c;
  logic signed [F+1:0]  xc5c, yc5c;
  logic [TW1-1:0]       xy5c;

  assign {th5c, in5c, xc5c, yc5c, xy5c} = htag[N_HORNER];
  assign snf = th5c * hss[N_HORNER];

  logic                   v5_r, v6_r, v7_r, v8_r;
  logic [F:0]             sn5_r, cs5_r;
  logic                   in5_r, in6_r, in7_r, in8_r;
  logic signed [F+1:0]    xc5_r, yc5_r;
  logic [TW1-1:0]         xy5_r, xy6_r, xy7_r, xy8_r;
  logic signed [2*F+3:0]  pcx6_r, psy6_r, pcy6_r, psx6_r;
  logic signed [2*F+4:0]  dx, dy;
  logic signed [F+4:0]    ax7_r, ay7_r;
  logic signed [F+18:0]   vx8_r, vy8_r;

  assign dx = pcx6_r - psy6_r;
  assign dy = pcy6_r + psx6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sn5_r  <= snf[2*F:F];
      cs5_r  <= hsc[N_HORNER];
      in5_r  <= in5c;
      xc5_r  <= xc5c;
      yc5_r  <= yc5c;
      xy5_r  <= xy5c;
      pcx6_r <= $signed({1'b0, cs5_r}) * xc5_r;
      psy6_r <= $signed({1'b0, sn5_r}) * yc5_r;
      pcy6_r <= $signed({1'b0, cs5_r}) * yc5_r;
      psx6_r <= $signed({1'b0, sn5_r}) * xc5_r;
      in6_r  <= in5_r;
      xy6_r  <= xy5_r;
      ax7_r  <= dx[2*F+4:F] + $signed({4'b0000, ONE});
      ay7_r  <= dy[2*F+4:F] + $signed({4'b0000, ONE});
      in7_r  <= in6_r;
      xy7_r  <= xy6_r;
      vx8_r  <= ax7_r * $signed({1'b0, wsize});
      vy8_r  <= ay7_r * $signed({1'b0, hsize});
      in8_r  <= in7_r;
      xy8_r  <= xy7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (en) begin
      v1_r <= dv[DW];
      v2_r <= v1_r;
      v3_r <= sv[QW];
      v4_r <= v3_r;
      v5_r <= hv[N_HORNER];
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  // final clamp and pass-through select
  logic [C-1:0] px, py, fx, fy;
  logic [C-1:0] sx_c, sy_c;

  always_comb begin
    px   = xy8_r[TW1-1:C];
    py   = xy8_r[C-1:0];
    fx   = clamp_idx(vx8_r[F+18:F+1], limx);
    fy   = clamp_idx(vy8_r[F+18:F+1], limy);
    sx_c = in8_r ? fx : clamp_idx($signed({{(18-C){1'b0}}, px}), limx);
    sy_c = in8_r ? fy : clamp_idx($signed({{(18-C){1'b0}}, py}), limy);
  end

  // output register with skid
  logic [C-1:0] out_x_r, out_y_r, skid_x_r, skid_y_r;
  logic         out_in_r, skid_in_r;

  assign push = en && v8_r;
  assign pop  = out_valid_r && out_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_x_r  <= skid_x_r;
        out_y_r  <= skid_y_r;
        out_in_r <= skid_in_r;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_x_r  <= sx_c;
        out_y_r  <= sy_c;
        out_in_r <= in8_r;
      end else begin
        skid_x_r  <= sx_c;
        skid_y_r  <= sy_c;
        skid_in_r <= in8_r;
      end
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.src_x       = out_x_r;
  assign out_bus.src_y       = out_y_r;
  assign out_bus.inside_disc = out_in_r;

`include "swirl_warp_coordinate_map_top_assert.svh"

  `SWM_ASSERT_IMP(a_skid_behind_out, skid_valid_r, out_valid_r, "skid full, output empty")
  `SWM_ASSERT_NXT(a_stall_fills_skid, out_valid_r && !out_bus.ready && push, skid_valid_r, "stalled beat lost")
  `SWM_ASSERT_IMP(a_src_in_frame, out_valid_r, (LB'(out_x_r) <= limx) && (LB'(out_y_r) <= limy), "source index beyond frame")

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// ---------------------------------------------------------------------------
// Swirl warp coordinate map testbench
// Streams pixel coordinates through the block under several frame sizes,
// predicts each source index in fixed point and checks every result beat
// in order, with random gaps on both channels except at the 4096 by 4096 size.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import swm_pkg::*;

  localparam int  CB   = 12;
  localparam int  FB   = 16;
  localparam real LIMIT_NS = 4000000.0;

  typedef struct packed {
    logic [CB-1:0] sx;
    logic [CB-1:0] sy;
    logic          in_disc;
  } src_beat_t;

  class warp_scoreboard;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    src_beat_t         pending_q[$];
    int                mismatches;
    int                n_inside;
    int                n_outside;
    int                n_checked;

    function new();
      width = WIDTH_RST;
      height = HEIGHT_RST;
      mismatches = 0;
      n_inside = 0;
      n_outside = 0;
      n_checked = 0;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, sq_bit;
      res = 0;
      sq_bit = 64'd1 << 62;
      while (sq_bit > v) sq_bit >>= 2;
      while (sq_bit != 0) begin
        if (v >= res + sq_bit) begin
          v -= res + sq_bit;
          res = (res >> 1) + sq_bit;
        end else begin
          res >>= 1;
        end
        sq_bit >>= 2;
      end
      return res;
    endfunction

    function logic [CB-1:0] clamp_idx(longint v, longint sz);
      longint lim;
      lim = sz - 1;
      if (lim > (1 << CB) - 1) lim = (1 << CB) - 1;
      if (v < 0) return '0;
      return (v > lim) ? lim[CB-1:0] : v[CB-1:0];
    endfunction

    function longint unsigned series(longint unsigned t2, int dv[], int n);
      longint unsigned s, one;
      one = 64'd1 << FB;
      s = one - t2 / dv[0];
      for (int i = 1; i < n; i++) s = one - ((t2 * s) >> FB) / dv[i];
      return s;
    endfunction

    function src_beat_t map_coord(logic [CB-1:0] x, logic [CB-1:0] y);
      src_beat_t b;
      longint w, h, one, xc, yc, sn, cs, xn, yn;
      longint unsigned r2, r, t, th, t2;
      int sdiv[] = '{72, 42, 20, 6};
      int cdiv[] = '{90, 56, 30, 12, 2};
      w = (width == 0) ? 1 : longint'(width);
      h = (height == 0) ? 1 : longint'(height);
      one = longint'(1) << FB;
      xc = ((longint'(x) << (FB + 1)) / w) - one;
      yc = ((longint'(y) << (FB + 1)) / h) - one;
      b.in_disc = 1'b0;
      if (xc <= one && xc >= -one && yc <= one && yc >= -one) begin
        r2 = xc * xc + yc * yc;
        if (r2 <= (64'd1 << (2 * FB))) begin
          r = int_sqrt(r2);
          t = one - r;
          th = (t * t) >> FB;
          t2 = (th * th) >> FB;
          sn = longint'((th * series(t2, sdiv, 4)) >> FB);
          cs = longint'(series(t2, cdiv, 5));
          xn = (cs * xc - sn * yc) >>> FB;
          yn = (cs * yc + sn * xc) >>> FB;
          b.sx = clamp_idx(((xn + one) * w) >>> (FB + 1), w);
          b.sy = clamp_idx(((yn + one) * h) >>> (FB + 1), h);
          b.in_disc = 1'b1;
        end
      end
      if (!b.in_disc) begin
        b.sx = clamp_idx(longint'(x), w);
        b.sy = clamp_idx(longint'(y), h);
      end
      return b;
    endfunction

    function void note_coord(logic [CB-1:0] x, logic [CB-1:0] y);
      pending_q.push_back(map_coord(x, y));
    endfunction

    function void check_result(src_beat_t got);
      src_beat_t exp_b;
      n_checked++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: sx=%0d sy=%0d disc=%0b",
                   got.sx, got.sy, got.in_disc);
        return;
      end
      exp_b = pending_q.pop_front();
      if (got.in_disc) n_inside++; else n_outside++;
      if (got !== exp_b) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected sx=%0d sy=%0d disc=%0b, got sx=%0d sy=%0d disc=%0b",
                   exp_b.sx, exp_b.sy, exp_b.in_disc, got.sx, got.sy, got.in_disc);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  bit          no_gaps;

  swm_in_if  #(.COORD_BITS(CB)) in_bus ();
  swm_out_if #(.COORD_BITS(CB)) out_bus ();

  swirl_warp_coordinate_map_top #(.COORD_BITS(CB), .FRAC_BITS(FB)) DUT (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  warp_scoreboard sb = new();

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  always @(posedge clk) begin
    if (!rst_n) out_bus.ready <= 1'b0;
    else out_bus.ready <= no_gaps || ($urandom_range(99) >= 36);
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready)
      sb.check_result('{out_bus.src_x, out_bus.src_y, out_bus.inside_disc});
  end

  task automatic write_reg(logic idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
    if (idx == REG_WIDTH) sb.width = val[SIZE_W-1:0];
    else sb.height = val[SIZE_W-1:0];
  endtask

  task automatic send_coord(logic [CB-1:0] x, logic [CB-1:0] y);
    while (!no_gaps && $urandom_range(99) < 36) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1; in_bus.out_x <= x; in_bus.out_y <= y;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_coord(x, y);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic run_random(int n);
    int w, h;
    logic [CB-1:0] x, y;
    w = (sb.width == 0) ? 1 : ((sb.width > 4096) ? 4096 : sb.width);
    h = (sb.height == 0) ? 1 : ((sb.height > 4096) ? 4096 : sb.height);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 80) begin
        x = CB'($urandom_range(w - 1));
        y = CB'($urandom_range(h - 1));
      end else begin
        x = CB'($urandom);
        y = CB'($urandom);
      end
      send_coord(x, y);
    end
  endtask

  initial begin
    int sizes[7][2] = '{'{640, 480}, '{1, 1}, '{0, 0}, '{4096, 4096},
                        '{8191, 8191}, '{17, 9}, '{3000, 100}};
    int hw, hh;
    rst_n = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0; no_gaps = 1'b0;
    in_bus.valid = 1'b0; in_bus.out_x = '0; in_bus.out_y = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int p = 0; p < 7; p++) begin
      if (p > 0) begin
        write_reg(REG_WIDTH, sizes[p][0]);
        write_reg(REG_HEIGHT, sizes[p][1]);
      end
      no_gaps = (p == 3);
      hw = sizes[p][0] / 2;
      hh = sizes[p][1] / 2;
      send_coord('0, '0);
      send_coord('1, '1);
      send_coord('0, '1);
      send_coord('1, '0);
      send_coord(hw[CB-1:0], hh[CB-1:0]);
      send_coord(hw[CB-1:0] + 1'b1, hh[CB-1:0]);
      send_coord(12'hAAA, 12'h555);
      run_random(270);
      drain();
    end
    $display("covered %0d result beats over 7 frame sizes (0, 1, 4096, 8191 among them)",
             sb.n_checked);
    $display("%0d swirled, %0d passed through", sb.n_inside, sb.n_outside);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("timeout");
    $display("testbench: FAIL");
    $finish;
  end
endmodule

/* swirl_warp_coordinate_map_top.f */
+incdir+src
src/swm_pkg.sv
src/swm_if.sv
src/swm_div_cell.sv
src/swm_sqrt_cell.sv
src/swm_horner_cell.sv
src/swirl_warp_coordinate_map_top.sv
tb/sv/testbench.sv
